FILE: hw/rtl/ifmt_pkg.sv
// ----------------------------------------------------------------------------
// ifmt_pkg: shared types and constants of the integer radix text formatter
// Widths, character codes, control structs and the digit-to-ASCII mapping.
// ----------------------------------------------------------------------------
package ifmt_pkg;

   localparam int MAX_CHARS = 64;
   localparam int DATA_W    = 64;
   localparam int RADIX_W   = 6;
   localparam int DIGIT_W   = 6;
   localparam int CHAR_W    = 7;
   localparam int WIDTH_W   = 7;
   localparam int ADDR_W    = $clog2(DATA_W);
   localparam int NDIG_W    = $clog2(DATA_W + 1);
   localparam int STEP_W    = $clog2(DATA_W);
   localparam int SPAN_W    = WIDTH_W + 1;

   localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
   localparam logic [RADIX_W-1:0] RADIX_DEC = RADIX_W'(10);

   localparam logic [WIDTH_W-1:0] LIMIT_RESET = WIDTH_W'(64);

   localparam logic [CHAR_W-1:0] CH_SPACE   = 7'h20;
   localparam logic [CHAR_W-1:0] CH_PLUS    = 7'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS   = 7'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO    = 7'h30;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;

   typedef struct packed {
      logic                done;
      logic [DATA_W-1:0]   quotient;
      logic [DIGIT_W-1:0]  remainder;
   } div_result_type;

   typedef struct packed {
      logic                en;
      logic [ADDR_W-1:0]   addr;
      logic [DIGIT_W-1:0]  data;
   } digit_write_type;

   typedef struct packed {
      logic                left_align;
      logic                pad_zeroes;
      logic                upper_case;
      logic                negative;
      logic                has_sign;
      logic [WIDTH_W-1:0]  pad;
      logic [WIDTH_W-1:0]  lead;
      logic [NDIG_W-1:0]   ndig;
      logic [WIDTH_W-1:0]  count;
   } plan_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                    input logic upper);
      logic [CHAR_W-1:0] base;
      base = upper ? CH_UPPER_A : CH_LOWER_A;
      if (d < DIGIT_W'(10)) begin
         digit_char = CH_ZERO + CHAR_W'(d);
      end else begin
         digit_char = base + CHAR_W'(d - DIGIT_W'(10));
      end
   endfunction

endpackage

FILE: hw/rtl/ifmt_divider.sv
// ----------------------------------------------------------------------------
// ifmt_divider: restoring shift-subtract divider
// Divides a 64-bit dividend by a small radix, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ifmt_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ifmt_pkg::DATA_W-1:0]   dividend,
   input  logic [ifmt_pkg::RADIX_W-1:0]  divisor,
   output ifmt_pkg::div_result_type      result
);

   logic [ifmt_pkg::DATA_W-1:0]  quo_ff, quo_in;
   logic [ifmt_pkg::DIGIT_W-1:0] rem_ff, rem_in;
   logic [ifmt_pkg::RADIX_W-1:0] div_ff;
   logic [ifmt_pkg::STEP_W-1:0]  cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [ifmt_pkg::DIGIT_W:0]   trial;
   logic                         fits;

   assign trial = {rem_ff, quo_ff[ifmt_pkg::DATA_W-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[ifmt_pkg::DATA_W-2:0], fits};
         rem_in = fits ? ifmt_pkg::DIGIT_W'(trial - {1'b0, div_ff})
                       : trial[ifmt_pkg::DIGIT_W-1:0];
         cnt_in = cnt_ff + ifmt_pkg::STEP_W'(1);
         if (cnt_ff == ifmt_pkg::STEP_W'(ifmt_pkg::DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         div_ff <= divisor;
      end
   end

   assign result.done      = done_ff;
   assign result.quotient  = quo_ff;
   assign result.remainder = rem_ff;

endmodule

FILE: hw/rtl/ifmt_emitter.sv
// ----------------------------------------------------------------------------
// ifmt_emitter: digit store and character sequencer
// Holds the digits and sends pad, sign and digits one beat at a time.
// ----------------------------------------------------------------------------
module ifmt_emitter (
   input  logic                           clock,
   input  logic                           reset,
   input  ifmt_pkg::digit_write_type      wr,
   input  logic                           start,
   input  ifmt_pkg::plan_type             plan,
   output logic                           done,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ifmt_pkg::CHAR_W-1:0]    rsp_character,
   output logic                           rsp_last
);

   typedef enum logic [3:0] {
      E_IDLE = 4'b0001,
      E_READ = 4'b0010,
      E_FORM = 4'b0100,
      E_SEND = 4'b1000
   } emit_state_type;

   emit_state_type                 state_ff, state_in;
   logic [ifmt_pkg::DIGIT_W-1:0]   digit_mem_ff [ifmt_pkg::DATA_W];
   logic [ifmt_pkg::DIGIT_W-1:0]   rd_data_ff;
   logic [ifmt_pkg::ADDR_W-1:0]    rd_addr;
   logic [ifmt_pkg::WIDTH_W-1:0]   pos_ff, pos_in, pos_inc;
   logic [ifmt_pkg::CHAR_W-1:0]    char_ff, char_in;
   logic                           last_ff;
   logic [ifmt_pkg::SPAN_W-1:0]    digit_end, base, diff;
   logic [ifmt_pkg::CHAR_W-1:0]    sign_ch, dig_ch;
   logic                           at_sign;

   assign digit_end = {1'b0, plan.lead} + ifmt_pkg::SPAN_W'(plan.ndig);
   assign base      = digit_end - ifmt_pkg::SPAN_W'(1);
   assign diff      = base - {1'b0, pos_ff};
   assign rd_addr   = diff[ifmt_pkg::ADDR_W-1:0];
   assign pos_inc   = pos_ff + ifmt_pkg::WIDTH_W'(1);

   assign sign_ch = plan.negative ? ifmt_pkg::CH_MINUS : ifmt_pkg::CH_PLUS;
   assign dig_ch  = ifmt_pkg::digit_char(rd_data_ff, plan.upper_case);
   assign at_sign = plan.has_sign && (pos_ff == '0);

   always_comb begin
      if (plan.left_align) begin
         if (at_sign) begin
            char_in = sign_ch;
         end else if ({1'b0, pos_ff} < digit_end) begin
            char_in = dig_ch;
         end else begin
            char_in = ifmt_pkg::CH_SPACE;
         end
      end else if (plan.pad_zeroes) begin
         if (at_sign) begin
            char_in = sign_ch;
         end else if (pos_ff < plan.lead) begin
            char_in = ifmt_pkg::CH_ZERO;
         end else begin
            char_in = dig_ch;
         end
      end else begin
         if (pos_ff < plan.pad) begin
            char_in = ifmt_pkg::CH_SPACE;
         end else if (pos_ff < plan.lead) begin
            char_in = sign_ch;
         end else begin
            char_in = dig_ch;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      done     = 1'b0;
      case (state_ff)
         E_IDLE: begin
            if (start) begin
               pos_in   = '0;
               state_in = E_READ;
            end
         end
         E_READ: begin
            state_in = E_FORM;
         end
         E_FORM: begin
            state_in = E_SEND;
         end
         E_SEND: begin
            if (!rsp_stall) begin
               if (last_ff) begin
                  done     = 1'b1;
                  state_in = E_IDLE;
               end else begin
                  pos_in   = pos_inc;
                  state_in = E_READ;
               end
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         digit_mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= digit_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (state_ff == E_FORM) begin
         char_ff <= char_in;
         last_ff <= (pos_inc == plan.count);
      end
   end

   assign rsp_valid     = (state_ff == E_SEND);
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

endmodule

FILE: hw/rtl/integer_radix_text_formatter_unit.sv
// Sequence: accept, then a full divider pass per digit, a planning state, then
//   each character through READ, FORM and SEND; SEND waits while rsp_stall is high.
// One value at a time: req_stall stays high from acceptance until the unit is idle.
// The digit loop is bound by the shared 64-step shift-subtract divider.
// Reset: synchronous, active high; idles and sets the output limit (limit_ff) to 64.
// ----------------------------------------------------------------------------
// integer_radix_text_formatter_unit: printf-style integer text formatter
// Converts a 64-bit value to radix text with sign, padding and truncation.
// ----------------------------------------------------------------------------
module integer_radix_text_formatter_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [ifmt_pkg::WIDTH_W-1:0]   csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ifmt_pkg::DATA_W-1:0]    req_value,
   input  logic                           req_is_signed,
   input  logic [ifmt_pkg::RADIX_W-1:0]   req_radix,
   input  logic                           req_upper_case,
   input  logic                           req_force_sign,
   input  logic                           req_left_align,
   input  logic                           req_pad_zeroes,
   input  logic [ifmt_pkg::WIDTH_W-1:0]   req_min_width,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ifmt_pkg::CHAR_W-1:0]    rsp_character,
   output logic                           rsp_last
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_DIV  = 4'b0010,
      S_PLAN = 4'b0100,
      S_EMIT = 4'b1000
   } state_type;

   state_type                      state_ff, state_in;
   logic [ifmt_pkg::WIDTH_W-1:0]   limit_ff;
   logic [ifmt_pkg::NDIG_W-1:0]    ndig_ff, ndig_in, ndig_inc;
   logic [ifmt_pkg::RADIX_W-1:0]   radix_ff;
   logic [ifmt_pkg::WIDTH_W-1:0]   width_ff;
   logic                           has_sign_ff, neg_ff, upper_ff, left_ff, zero_ff;
   ifmt_pkg::plan_type             plan_ff, plan_in;

   logic                           accept, radix_ok, signed_eff, neg, has_sign;
   logic [ifmt_pkg::DATA_W-1:0]    magnitude;
   logic                           div_start;
   logic [ifmt_pkg::DATA_W-1:0]    div_dividend;
   logic [ifmt_pkg::RADIX_W-1:0]   div_divisor;
   ifmt_pkg::div_result_type       div_res;
   ifmt_pkg::digit_write_type      dig_wr;
   logic                           emit_start, emit_done;

   logic [ifmt_pkg::WIDTH_W-1:0]   total, pad, len, lim;

   assign req_stall  = (state_ff != S_IDLE);
   assign accept     = req_valid && !req_stall;
   assign radix_ok   = (req_radix >= ifmt_pkg::RADIX_MIN) && (req_radix <= ifmt_pkg::RADIX_MAX);
   assign signed_eff = req_is_signed && (req_radix == ifmt_pkg::RADIX_DEC);
   assign neg        = signed_eff && req_value[ifmt_pkg::DATA_W-1];
   assign has_sign   = neg || (signed_eff && req_force_sign && (req_value != '0));
   assign magnitude  = neg ? (~req_value + ifmt_pkg::DATA_W'(1)) : req_value;
   assign ndig_inc   = ndig_ff + ifmt_pkg::NDIG_W'(1);

   assign total = ifmt_pkg::WIDTH_W'(ndig_ff) + ifmt_pkg::WIDTH_W'(has_sign_ff);
   assign pad   = (width_ff > total) ? (width_ff - total) : '0;
   assign len   = pad + total;
   assign lim   = (limit_ff > ifmt_pkg::WIDTH_W'(ifmt_pkg::MAX_CHARS))
                  ? ifmt_pkg::WIDTH_W'(ifmt_pkg::MAX_CHARS) : limit_ff;

   always_comb begin
      plan_in.left_align = left_ff;
      plan_in.pad_zeroes = zero_ff;
      plan_in.upper_case = upper_ff;
      plan_in.negative   = neg_ff;
      plan_in.has_sign   = has_sign_ff;
      plan_in.pad        = pad;
      plan_in.lead       = left_ff ? ifmt_pkg::WIDTH_W'(has_sign_ff)
                                   : pad + ifmt_pkg::WIDTH_W'(has_sign_ff);
      plan_in.ndig       = ndig_ff;
      plan_in.count      = (len < lim) ? len : lim;
   end

   always_comb begin
      state_in     = state_ff;
      ndig_in      = ndig_ff;
      div_start    = 1'b0;
      div_dividend = div_res.quotient;
      div_divisor  = radix_ff;
      dig_wr.en    = 1'b0;
      dig_wr.addr  = ndig_ff[ifmt_pkg::ADDR_W-1:0];
      dig_wr.data  = div_res.remainder;
      emit_start   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept && radix_ok) begin
               div_start    = 1'b1;
               div_dividend = magnitude;
               div_divisor  = req_radix;
               ndig_in      = '0;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            if (div_res.done) begin
               dig_wr.en = 1'b1;
               ndig_in   = ndig_inc;
               if ((div_res.quotient != '0) &&
                   (ndig_inc < ifmt_pkg::NDIG_W'(ifmt_pkg::DATA_W))) begin
                  div_start = 1'b1;
               end else begin
                  state_in = S_PLAN;
               end
            end
         end
         S_PLAN: begin
            if (plan_in.count != '0) begin
               emit_start = 1'b1;
               state_in   = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (emit_done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         limit_ff <= ifmt_pkg::LIMIT_RESET;
         ndig_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ndig_ff  <= ndig_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         radix_ff    <= req_radix;
         width_ff    <= (req_min_width == '0) ? ifmt_pkg::WIDTH_W'(1) : req_min_width;
         has_sign_ff <= has_sign;
         neg_ff      <= neg;
         upper_ff    <= req_upper_case;
         left_ff     <= req_left_align;
         zero_ff     <= req_pad_zeroes;
      end
      if (state_ff == S_PLAN) begin
         plan_ff <= plan_in;
      end
   end

   ifmt_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .result   (div_res)
   );

   ifmt_emitter u_emitter (
      .clock         (clock),
      .reset         (reset),
      .wr            (dig_wr),
      .start         (emit_start),
      .plan          (plan_ff),
      .done          (emit_done),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

`ifndef SYNTHESIS
   a_rsp_only_in_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == S_EMIT))
      else $error("result beat outside emit phase");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid)
      else $error("input taken while a result beat is pending");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> (state_ff == S_DIV))
      else $error("divider finished outside digit phase");

   a_digit_count_bound: assert property (@(posedge clock) disable iff (reset)
      ndig_ff <= ifmt_pkg::NDIG_W'(ifmt_pkg::DATA_W))
      else $error("digit count overflow");
`endif

endmodule
